// ===== hw/rtl/tcw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

   // payload widths of the channels
   localparam int FUNC_W       = 2;
   localparam int CHAR_W       = 8;
   localparam int HEX_W        = 64;
   localparam int READ_ROW_W   = 5;
   localparam int READ_COL_W   = 7;
   localparam int CURSOR_ROW_W = 6;
   localparam int CURSOR_COL_W = 7;

   // character codes and fixed values
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'h0a;
   localparam logic [CHAR_W-1:0] CHAR_BLANK     = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_ZERO      = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_HEX_ALPHA = 8'h57;
   localparam int                RESET_ROW      = 5;
   localparam int                HEX_DIGITS     = 16;
   localparam int                HEX_LEFT_W     = 5;

   // request function codes
   typedef enum logic [FUNC_W-1:0] {
      FUNC_PUT  = 2'd0,
      FUNC_HEX  = 2'd1,
      FUNC_READ = 2'd2,
      FUNC_NOP  = 2'd3
   } func_type;

   // microprogram addresses
   typedef enum logic [3:0] {
      U_CLEAR     = 4'd0,
      U_IDLE      = 4'd1,
      U_PUT       = 4'd2,
      U_FULL      = 4'd3,
      U_CHECK     = 4'd4,
      U_SCROLL    = 4'd5,
      U_BLANK     = 4'd6,
      U_LOOP      = 4'd7,
      U_WRITE     = 4'd8,
      U_FIN       = 4'd9,
      U_RESP      = 4'd10,
      U_RESP_WAIT = 4'd11,
      U_NEWLINE   = 4'd12,
      U_HEX       = 4'd13,
      U_READ      = 4'd14,
      U_READ_CAP  = 4'd15
   } upc_type;

   // jump conditions
   typedef enum logic [3:0] {
      C_NEXT,
      C_ALWAYS,
      C_CLEAR_MORE,
      C_DISPATCH,
      C_IS_NL,
      C_COL_FULL,
      C_ROW_IN,
      C_SWEEP_MORE,
      C_HEX_MORE,
      C_SLOT_FREE
   } cond_type;

   // datapath operations
   typedef enum logic [3:0] {
      OP_NONE,
      OP_CLEAR,
      OP_ACCEPT,
      OP_SCROLL,
      OP_BLANK,
      OP_WRITE,
      OP_NEWLINE,
      OP_HEX_LOAD,
      OP_READ,
      OP_READ_CAP,
      OP_RESP
   } op_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      upc_type  target;
   } ucode_type;

   // control from sequencer to datapath
   typedef struct packed {
      op_type op;
   } ctrl_type;

   // status from datapath to sequencer
   typedef struct packed {
      logic     fire;
      func_type func;
      logic     is_nl;
      logic     col_full;
      logic     row_in;
      logic     clear_last;
      logic     col_last;
      logic     hex_more;
      logic     slot_busy;
   } status_type;

   // control store
   function automatic ucode_type ucode_rom(input upc_type addr);
      ucode_type w;
      case (addr)
         U_CLEAR:     w = '{OP_CLEAR,    C_CLEAR_MORE, U_CLEAR};
         U_IDLE:      w = '{OP_ACCEPT,   C_DISPATCH,   U_IDLE};
         U_PUT:       w = '{OP_NONE,     C_IS_NL,      U_NEWLINE};
         U_FULL:      w = '{OP_NONE,     C_COL_FULL,   U_FIN};
         U_CHECK:     w = '{OP_NONE,     C_ROW_IN,     U_WRITE};
         U_SCROLL:    w = '{OP_SCROLL,   C_NEXT,       U_BLANK};
         U_BLANK:     w = '{OP_BLANK,    C_SWEEP_MORE, U_BLANK};
         U_LOOP:      w = '{OP_NONE,     C_ALWAYS,     U_CHECK};
         U_WRITE:     w = '{OP_WRITE,    C_NEXT,       U_FIN};
         U_FIN:       w = '{OP_NONE,     C_HEX_MORE,   U_HEX};
         U_RESP:      w = '{OP_RESP,     C_SLOT_FREE,  U_IDLE};
         U_RESP_WAIT: w = '{OP_NONE,     C_ALWAYS,     U_RESP};
         U_NEWLINE:   w = '{OP_NEWLINE,  C_ALWAYS,     U_FIN};
         U_HEX:       w = '{OP_HEX_LOAD, C_ALWAYS,     U_PUT};
         U_READ:      w = '{OP_READ,     C_NEXT,       U_READ_CAP};
         U_READ_CAP:  w = '{OP_READ_CAP, C_ALWAYS,     U_RESP};
         default:     w = '{OP_NONE,     C_ALWAYS,     U_IDLE};
      endcase
      return w;
   endfunction

   // entry point of each request function
   function automatic upc_type dispatch(input func_type f);
      upc_type a;
      case (f)
         FUNC_PUT:  a = U_PUT;
         FUNC_HEX:  a = U_HEX;
         FUNC_READ: a = U_READ;
         FUNC_NOP:  a = U_RESP;
         default:   a = U_RESP;
      endcase
      return a;
   endfunction

   // lower-case hex digit
   function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
      logic [CHAR_W-1:0] ext;
      ext = {4'h0, nib};
      return (nib < 4'd10) ? (CHAR_ZERO + ext) : (CHAR_HEX_ALPHA + ext);
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tcw_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// request channel
interface tcw_req_if;
   import tcw_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [FUNC_W-1:0]     func;
   logic [CHAR_W-1:0]     char_code;
   logic [HEX_W-1:0]      hex_value;
   logic [READ_ROW_W-1:0] read_row;
   logic [READ_COL_W-1:0] read_col;

   modport source (output valid, func, char_code, hex_value, read_row, read_col,
                   input ready);
   modport sink (input valid, func, char_code, hex_value, read_row, read_col,
                 output ready);
endinterface

// response channel
interface tcw_rsp_if;
   import tcw_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [CHAR_W-1:0]       read_char;
   logic [CURSOR_ROW_W-1:0] cursor_row;
   logic [CURSOR_COL_W-1:0] cursor_col;

   modport source (output valid, read_char, cursor_row, cursor_col, input ready);
   modport sink (input valid, read_char, cursor_row, cursor_col, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tcw_grid_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tcw_grid_ram #(
   parameter int DEPTH  = 3200,
   parameter int ADDR_W = 12
) (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [ADDR_W-1:0]         wr_addr,
   input  wire logic [tcw_pkg::CHAR_W-1:0] wr_data,
   input  wire logic                      rd_en,
   input  wire logic [ADDR_W-1:0]         rd_addr,
   output logic      [tcw_pkg::CHAR_W-1:0] rd_data
);
   import tcw_pkg::*;

   logic [CHAR_W-1:0] mem [DEPTH];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/tcw_sequencer.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tcw_sequencer (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire tcw_pkg::status_type status,
   output tcw_pkg::ctrl_type        ctrl
);
   import tcw_pkg::*;

   upc_type   upc_ff;
   upc_type   upc_in;
   ucode_type word;

   assign word = ucode_rom(upc_ff);

   // next step: jump when the condition holds, else fall through; dispatch waits in place until a request fires
   always_comb begin
      upc_in = upc_type'(upc_ff + 4'd1);
      case (word.cond)
         C_NEXT:       upc_in = upc_type'(upc_ff + 4'd1);
         C_ALWAYS:     upc_in = word.target;
         C_CLEAR_MORE: if (!status.clear_last) upc_in = word.target;
         C_DISPATCH: begin
            upc_in = status.fire ? dispatch(status.func) : upc_ff;
         end
         C_IS_NL:      if (status.is_nl) upc_in = word.target;
         C_COL_FULL:   if (status.col_full) upc_in = word.target;
         C_ROW_IN:     if (status.row_in) upc_in = word.target;
         C_SWEEP_MORE: if (!status.col_last) upc_in = word.target;
         C_HEX_MORE:   if (status.hex_more) upc_in = word.target;
         C_SLOT_FREE:  if (!status.slot_busy) upc_in = word.target;
         default:      upc_in = U_IDLE;
      endcase
   end

   // control word out
   always_comb begin
      ctrl.op = word.op;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= U_CLEAR;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/text_console_writer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Text console writer holding a ROWS x COLS character grid and a write cursor.
// Requests arrive on req_if (valid/ready): func 0 puts char_code, func 1 prints
// hex_value as sixteen lower-case hex digits, func 2 reads the cell at
// read_row/read_col. Every request gives one response on rsp_if with the cell
// read (zero unless a read in range) and the cursor after the request.
// One request is worked at a time by a microcoded sequencer; req_if.ready is
// high only in its idle step, which follows the response step, so a new request
// can transfer in the cycle after its predecessor's response is loaded. A plain
// character runs the put, full, check, write and finish steps before the
// response, a newline its newline step, a read the read and capture steps, and
// a hex print the put path once per digit. A scroll of one row blanks the bottom
// row one cell per cycle through the single grid write port; scrolling itself
// only moves a row base.
// After reset the grid is cleared to spaces one cell per cycle, all ROWS * COLS
// cells (2000 at the defaults), before the first request is taken.
// The response sits in an output register; the next request is accepted while
// it waits, and the sequencer circles between its response and wait steps while
// the receiver stalls with the register still full.
module text_console_writer #(
   parameter int ROWS = 25,
   parameter int COLS = 80
) (
   input wire logic clock,
   input wire logic reset,
   tcw_req_if.sink   req_if,
   tcw_rsp_if.source rsp_if
);
   import tcw_pkg::*;

   localparam int RW      = $clog2(ROWS);
   localparam int CW      = $clog2(COLS);
   localparam int RPW     = $clog2(2 * ROWS);
   localparam int CPW     = $clog2(COLS + 1);
   localparam int ADDR_W  = RW + CW;
   localparam int DEPTH   = ROWS * (1 << CW);
   localparam int ROW_CAP = 2 * ROWS - 1;
   localparam int ROW_INI = (RESET_ROW > ROW_CAP) ? ROW_CAP : RESET_ROW;

   localparam logic [RPW-1:0] ROWS_R    = RPW'(ROWS);
   localparam logic [RPW-1:0] CAP_R     = RPW'(ROW_CAP);
   localparam logic [CPW-1:0] COLS_C    = CPW'(COLS);
   localparam logic [RW:0]    ROWS_P    = (RW + 1)'(ROWS);
   localparam logic [RW-1:0]  LAST_ROW  = RW'(ROWS - 1);
   localparam logic [CW-1:0]  LAST_COL  = CW'(COLS - 1);

   ctrl_type   ctrl;
   status_type status;

   // control registers
   logic [RPW-1:0]        row_ff, row_in;
   logic [CPW-1:0]        col_ff, col_in;
   logic [RW-1:0]         base_ff, base_in;
   logic [RW-1:0]         sw_row_ff, sw_row_in;
   logic [CW-1:0]         sw_col_ff, sw_col_in;
   logic [HEX_LEFT_W-1:0] hex_left_ff, hex_left_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [CHAR_W-1:0]       ch_ff, ch_in;
   logic [HEX_W-1:0]        shift_ff, shift_in;
   logic [RW-1:0]           rrow_ff, rrow_in;
   logic [CW-1:0]           rcol_ff, rcol_in;
   logic                    rd_ok_ff, rd_ok_in;
   logic [CHAR_W-1:0]       rd_ff, rd_in;
   logic [CHAR_W-1:0]       rsp_char_ff, rsp_char_in;
   logic [CURSOR_ROW_W-1:0] rsp_row_ff, rsp_row_in;
   logic [CURSOR_COL_W-1:0] rsp_col_ff, rsp_col_in;

   logic              fire;
   logic              rsp_fire;
   logic              slot_busy;
   logic [RW-1:0]     lrow;
   logic [RW:0]       psum;
   logic [RW-1:0]     prow;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [CHAR_W-1:0] wr_data;
   logic              rd_en;
   logic [CHAR_W-1:0] ram_q;

   assign req_if.ready = (ctrl.op == OP_ACCEPT);
   assign fire         = req_if.valid && req_if.ready;
   assign rsp_fire     = rsp_valid_ff && rsp_if.ready;
   assign slot_busy    = rsp_valid_ff && !rsp_if.ready;

   // flags for the sequencer
   always_comb begin
      status.fire       = fire;
      status.func       = func_type'(req_if.func);
      status.is_nl      = (ch_ff == CHAR_NEWLINE);
      status.col_full   = (col_ff >= COLS_C);
      status.row_in     = (row_ff < ROWS_R);
      status.clear_last = (sw_row_ff == LAST_ROW) && (sw_col_ff == LAST_COL);
      status.col_last   = (sw_col_ff == LAST_COL);
      status.hex_more   = (hex_left_ff != '0);
      status.slot_busy  = slot_busy;
   end

   // logical to physical row through the scroll base
   always_comb begin
      lrow = (ctrl.op == OP_READ) ? rrow_ff : row_ff[RW-1:0];
      psum = {1'b0, base_ff} + {1'b0, lrow};
      prow = (psum >= ROWS_P) ? RW'(psum - ROWS_P) : psum[RW-1:0];
   end

   // grid port control
   always_comb begin
      wr_en   = (ctrl.op == OP_CLEAR) || (ctrl.op == OP_BLANK) || (ctrl.op == OP_WRITE);
      wr_data = (ctrl.op == OP_WRITE) ? ch_ff : CHAR_BLANK;
      wr_addr = (ctrl.op == OP_WRITE) ? {prow, col_ff[CW-1:0]} : {sw_row_ff, sw_col_ff};
      rd_en   = (ctrl.op == OP_READ) && rd_ok_ff;
   end

   // datapath next values
   always_comb begin
      row_in      = row_ff;
      col_in      = col_ff;
      base_in     = base_ff;
      sw_row_in   = sw_row_ff;
      sw_col_in   = sw_col_ff;
      hex_left_in = hex_left_ff;
      ch_in       = ch_ff;
      shift_in    = shift_ff;
      rrow_in     = rrow_ff;
      rcol_in     = rcol_ff;
      rd_ok_in    = rd_ok_ff;
      rd_in       = rd_ff;
      rsp_char_in = rsp_char_ff;
      rsp_row_in  = rsp_row_ff;
      rsp_col_in  = rsp_col_ff;
      rsp_valid_in = rsp_fire ? 1'b0 : rsp_valid_ff;
      case (ctrl.op)
         OP_CLEAR: begin
            if (sw_col_ff == LAST_COL) begin
               sw_col_in = '0;
               sw_row_in = sw_row_ff + 1'b1;
            end else begin
               sw_col_in = sw_col_ff + 1'b1;
            end
         end
         OP_ACCEPT: begin
            if (fire) begin
               ch_in       = req_if.char_code;
               shift_in    = req_if.hex_value;
               hex_left_in = (func_type'(req_if.func) == FUNC_HEX) ?
                             HEX_LEFT_W'(HEX_DIGITS) : '0;
               rrow_in     = RW'(req_if.read_row);
               rcol_in     = CW'(req_if.read_col);
               rd_ok_in    = (7'(req_if.read_row) < 7'(ROWS)) &&
                             (8'(req_if.read_col) < 8'(COLS));
               rd_in       = '0;
            end
         end
         OP_SCROLL: begin
            // old base row becomes the new bottom row
            base_in   = (base_ff == LAST_ROW) ? '0 : base_ff + 1'b1;
            sw_row_in = base_ff;
            sw_col_in = '0;
            row_in    = row_ff - 1'b1;
         end
         OP_BLANK: begin
            sw_col_in = sw_col_ff + 1'b1;
         end
         OP_WRITE: begin
            col_in = col_ff + 1'b1;
         end
         OP_NEWLINE: begin
            col_in = '0;
            if (row_ff < CAP_R) begin
               row_in = row_ff + 1'b1;
            end
         end
         OP_HEX_LOAD: begin
            ch_in       = hex_char(shift_ff[HEX_W-1 -: 4]);
            shift_in    = {shift_ff[HEX_W-5:0], 4'h0};
            hex_left_in = hex_left_ff - 1'b1;
         end
         OP_READ: begin
         end
         OP_READ_CAP: begin
            rd_in = rd_ok_ff ? ram_q : '0;
         end
         OP_RESP: begin
            if (!slot_busy) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = rd_ff;
               rsp_row_in   = CURSOR_ROW_W'(row_ff);
               rsp_col_in   = CURSOR_COL_W'(col_ff);
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff       <= RPW'(ROW_INI);
         col_ff       <= '0;
         base_ff      <= '0;
         sw_row_ff    <= '0;
         sw_col_ff    <= '0;
         hex_left_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_ff       <= row_in;
         col_ff       <= col_in;
         base_ff      <= base_in;
         sw_row_ff    <= sw_row_in;
         sw_col_ff    <= sw_col_in;
         hex_left_ff  <= hex_left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ch_ff       <= ch_in;
      shift_ff    <= shift_in;
      rrow_ff     <= rrow_in;
      rcol_ff     <= rcol_in;
      rd_ok_ff    <= rd_ok_in;
      rd_ff       <= rd_in;
      rsp_char_ff <= rsp_char_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_col_ff  <= rsp_col_in;
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.read_char  = rsp_char_ff;
   assign rsp_if.cursor_row = rsp_row_ff;
   assign rsp_if.cursor_col = rsp_col_ff;

   tcw_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   tcw_grid_ram #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_grid (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr ({prow, rcol_ff}),
      .rd_data (ram_q)
   );

endmodule

`default_nettype wire

// ===== tb/sv/text_console_writer_test.sv =====
`timescale 1ns / 1ps

module text_console_writer_test;
   import tcw_pkg::*;

   localparam int     ROWS       = 25;
   localparam int     COLS       = 80;
   localparam int     ROW_CAP    = 2 * ROWS - 1;
   localparam int     ITEMS      = 1500;
   localparam int     DRAIN      = 200;
   localparam int     MAX_SHOWN  = 100;
   localparam longint LIMIT_NS   = 20_000_000;
   localparam int     SCRIPT_LEN = 25;

   // glyph bases for hex digits
   localparam logic [CHAR_W-1:0] GLYPH_DIGIT  = 8'h30;
   localparam logic [CHAR_W-1:0] GLYPH_LETTER = 8'h61;
   localparam logic [3:0]        DECIMAL_TOP  = 4'd10;

   typedef struct packed {
      func_type              func;
      logic [CHAR_W-1:0]     char_code;
      logic [HEX_W-1:0]      hex_value;
      logic [READ_ROW_W-1:0] read_row;
      logic [READ_COL_W-1:0] read_col;
   } console_req_type;

   typedef struct packed {
      logic [CHAR_W-1:0]       read_char;
      logic [CURSOR_ROW_W-1:0] cursor_row;
      logic [CURSOR_COL_W-1:0] cursor_col;
   } console_rsp_type;

   typedef struct packed {
      console_req_type req;
      logic            fixed;
      console_rsp_type rsp;
   } script_row_type;

   // directed rows; fixed rows carry their reply, the rest go through the predictor
   localparam script_row_type SCRIPT [SCRIPT_LEN] = '{
      '{'{FUNC_READ, 8'h00, 64'h0, 5'd0, 7'd0}, 1'b1, '{8'h20, 6'd5, 7'd0}},
      '{'{FUNC_READ, 8'h00, 64'h0, 5'd24, 7'd79}, 1'b1, '{8'h20, 6'd5, 7'd0}},
      '{'{FUNC_READ, 8'h00, 64'h0, 5'd25, 7'd0}, 1'b1, '{8'h00, 6'd5, 7'd0}},
      '{'{FUNC_READ, 8'hff, 64'h0, 5'd31, 7'd127}, 1'b1, '{8'h00, 6'd5, 7'd0}},
      '{'{FUNC_READ, 8'h00, 64'h0, 5'd0, 7'd80}, 1'b1, '{8'h00, 6'd5, 7'd0}},
      '{'{FUNC_NOP, 8'hff, 64'hffff_ffff_ffff_ffff, 5'd1, 7'd1}, 1'b1,
        '{8'h00, 6'd5, 7'd0}},
      '{'{FUNC_PUT, 8'h41, 64'hffff_ffff_ffff_ffff, 5'd31, 7'd127}, 1'b1,
        '{8'h00, 6'd5, 7'd1}},
      '{'{FUNC_PUT, 8'h00, 64'h0, 5'd0, 7'd0}, 1'b1, '{8'h00, 6'd5, 7'd2}},
      '{'{FUNC_PUT, 8'hff, 64'h0, 5'd0, 7'd0}, 1'b1, '{8'h00, 6'd5, 7'd3}},
      '{'{FUNC_READ, 8'h00, 64'h0, 5'd5, 7'd0}, 1'b1, '{8'h41, 6'd5, 7'd3}},
      '{'{FUNC_READ, 8'h00, 64'h0, 5'd5, 7'd1}, 1'b1, '{8'h00, 6'd5, 7'd3}},
      '{'{FUNC_READ, 8'h00, 64'h0, 5'd5, 7'd2}, 1'b1, '{8'hff, 6'd5, 7'd3}},
      '{'{FUNC_PUT, CHAR_NEWLINE, 64'h0, 5'd0, 7'd0}, 1'b1, '{8'h00, 6'd6, 7'd0}},
      '{'{FUNC_HEX, 8'h00, 64'h0, 5'd0, 7'd0}, 1'b1, '{8'h00, 6'd6, 7'd16}},
      '{'{FUNC_HEX, 8'h00, 64'hffff_ffff_ffff_ffff, 5'd0, 7'd0}, 1'b1,
        '{8'h00, 6'd6, 7'd32}},
      '{'{FUNC_HEX, 8'h00, 64'h0123_4567_89ab_cdef, 5'd0, 7'd0}, 1'b1,
        '{8'h00, 6'd6, 7'd48}},
      '{'{FUNC_READ, 8'h00, 64'h0, 5'd6, 7'd47}, 1'b0, '0},
      '{'{FUNC_READ, 8'h00, 64'h0, 5'd6, 7'd32}, 1'b0, '0},
      '{'{FUNC_HEX, 8'h00, 64'hfedc_ba98_7654_3210, 5'd0, 7'd0}, 1'b1,
        '{8'h00, 6'd6, 7'd64}},
      '{'{FUNC_HEX, 8'h00, 64'h5a5a_c3c3_0f0f_9669, 5'd0, 7'd0}, 1'b1,
        '{8'h00, 6'd6, 7'd80}},
      '{'{FUNC_PUT, 8'h78, 64'h0, 5'd0, 7'd0}, 1'b1, '{8'h00, 6'd6, 7'd80}},
      '{'{FUNC_HEX, 8'h00, 64'hdead_beef_0bad_f00d, 5'd0, 7'd0}, 1'b1,
        '{8'h00, 6'd6, 7'd80}},
      '{'{FUNC_READ, 8'h00, 64'h0, 5'd6, 7'd79}, 1'b0, '0},
      '{'{FUNC_PUT, CHAR_NEWLINE, 64'h0, 5'd0, 7'd0}, 1'b1, '{8'h00, 6'd7, 7'd0}},
      '{'{FUNC_READ, 8'h00, 64'h0, 5'd7, 7'd0}, 1'b1, '{8'h20, 6'd7, 7'd0}}
   };

   logic clock;
   logic reset;

   tcw_req_if req_if ();
   tcw_rsp_if rsp_if ();

   text_console_writer u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   // predicted screen and cursor
   logic [CHAR_W-1:0] screen [ROWS][COLS];
   int unsigned       cur_row;
   int unsigned       cur_col;

   console_rsp_type reply_q [$];
   int              fail_count;
   int              sent_count;
   int              reply_count;
   bit              send_calm;
   bit              take_calm;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #(LIMIT_NS);
      $display("Verification failed");
      $finish;
   end

   task automatic report_mismatch(input string what);
      fail_count++;
      if (fail_count <= MAX_SHOWN) $display("mismatch at %0t: %s", $time, what);
   endtask

   // one byte onto the predicted screen
   function automatic void write_glyph(input logic [CHAR_W-1:0] ch);
      if (ch == CHAR_NEWLINE) begin
         cur_col = 0;
         if (cur_row < ROW_CAP) cur_row++;
      end else if (cur_col < COLS) begin
         // scroll up until the cursor row is on screen
         while (cur_row >= ROWS) begin
            for (int r = 0; r < ROWS - 1; r++)
               for (int c = 0; c < COLS; c++)
                  screen[r][c] = screen[r + 1][c];
            for (int c = 0; c < COLS; c++)
               screen[ROWS - 1][c] = CHAR_BLANK;
            cur_row--;
         end
         screen[cur_row][cur_col] = ch;
         cur_col++;
      end
   endfunction

   // reply of the console to one request
   function automatic console_rsp_type console_step(input console_req_type it);
      console_rsp_type r;
      logic [3:0]      nib;
      r = '0;
      case (it.func)
         FUNC_PUT: begin
            write_glyph(it.char_code);
         end
         FUNC_HEX: begin
            for (int i = HEX_DIGITS - 1; i >= 0; i--) begin
               nib = it.hex_value[i * 4 +: 4];
               write_glyph(nib < DECIMAL_TOP ? GLYPH_DIGIT + CHAR_W'(nib)
                                             : GLYPH_LETTER + CHAR_W'(nib - DECIMAL_TOP));
            end
         end
         FUNC_READ: begin
            if (it.read_row < ROWS && it.read_col < COLS)
               r.read_char = screen[it.read_row][it.read_col];
         end
         default: begin
         end
      endcase
      r.cursor_row = CURSOR_ROW_W'(cur_row);
      r.cursor_col = CURSOR_COL_W'(cur_col);
      return r;
   endfunction

   function automatic int unsigned pick_gap(input bit calm);
      int unsigned roll;
      if (calm) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // request with every field random, weighted toward puts and reads
   function automatic console_req_type random_req();
      console_req_type it;
      int unsigned     roll;
      it.func      = FUNC_NOP;
      it.char_code = CHAR_W'($urandom);
      it.hex_value = {$urandom, $urandom};
      it.read_row  = READ_ROW_W'($urandom);
      it.read_col  = READ_COL_W'($urandom);
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
         it.func = FUNC_PUT;
         if ($urandom_range(0, 99) < 15) it.char_code = CHAR_NEWLINE;
      end else if (roll < 67) begin
         it.func = FUNC_HEX;
      end else if (roll < 95) begin
         it.func = FUNC_READ;
         roll = $urandom_range(0, 99);
         if (roll < 60) begin
            it.read_row = READ_ROW_W'($urandom_range(0, ROWS - 1));
            it.read_col = READ_COL_W'($urandom_range(0, COLS - 1));
         end else if (roll < 80) begin
            // the cell just written
            it.read_row = READ_ROW_W'(cur_row < ROWS ? cur_row : ROWS - 1);
            it.read_col = READ_COL_W'(cur_col > 0 ? cur_col - 1 : 0);
         end
      end
      return it;
   endfunction

   // random put of a byte that is not a newline
   function automatic console_req_type glyph_req();
      console_req_type it;
      it = random_req();
      it.func = FUNC_PUT;
      if (it.char_code == CHAR_NEWLINE) it.char_code = CHAR_BLANK;
      return it;
   endfunction

   // one request transfer; valid stays high for a back-to-back follower
   task automatic send_req(input console_req_type it, input bit fixed,
                           input console_rsp_type fixed_rsp);
      int unsigned     gap;
      console_rsp_type predicted;
      gap = pick_gap(send_calm);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.func      <= it.func;
      req_if.char_code <= it.char_code;
      req_if.hex_value <= it.hex_value;
      req_if.read_row  <= it.read_row;
      req_if.read_col  <= it.read_col;
      do @(posedge clock); while (!req_if.ready);
      predicted = console_step(it);
      reply_q.push_back(fixed ? fixed_rsp : predicted);
      sent_count++;
   endtask

   // response side: random stalls and the in-order check
   initial begin
      console_rsp_type got;
      console_rsp_type want;
      int unsigned     stall_left;
      stall_left = 0;
      take_calm = 1'b0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_if.valid && rsp_if.ready) begin
            got = '{rsp_if.read_char, rsp_if.cursor_row, rsp_if.cursor_col};
            if (reply_q.size() == 0) begin
               report_mismatch($sformatf("reply %0d with none outstanding", reply_count));
            end else begin
               want = reply_q.pop_front();
               if (got.read_char != want.read_char)
                  report_mismatch($sformatf("reply %0d read_char %02h, want %02h",
                                            reply_count, got.read_char, want.read_char));
               if (got.cursor_row != want.cursor_row)
                  report_mismatch($sformatf("reply %0d cursor_row %0d, want %0d",
                                            reply_count, got.cursor_row, want.cursor_row));
               if (got.cursor_col != want.cursor_col)
                  report_mismatch($sformatf("reply %0d cursor_col %0d, want %0d",
                                            reply_count, got.cursor_col, want.cursor_col));
            end
            reply_count++;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            stall_left = pick_gap(take_calm);
            if ($urandom_range(0, 199) == 0) take_calm = !take_calm;
         end
      end
   end

   // stimulus
   initial begin
      int unsigned  roll;
      int unsigned  run;
      bit           paused;
      reset            <= 1'b1;
      req_if.valid     <= 1'b0;
      req_if.func      <= '0;
      req_if.char_code <= '0;
      req_if.hex_value <= '0;
      req_if.read_row  <= '0;
      req_if.read_col  <= '0;
      fail_count  = 0;
      sent_count  = 0;
      reply_count = 0;
      send_calm   = 1'b0;
      paused      = 1'b0;
      for (int r = 0; r < ROWS; r++)
         for (int c = 0; c < COLS; c++)
            screen[r][c] = CHAR_BLANK;
      cur_row = (RESET_ROW > ROW_CAP) ? ROW_CAP : RESET_ROW;
      cur_col = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (int i = 0; i < SCRIPT_LEN; i++)
         send_req(SCRIPT[i].req, SCRIPT[i].fixed, SCRIPT[i].rsp);

      // random sequences
      while (sent_count < SCRIPT_LEN + ITEMS) begin
         if ($urandom_range(0, 9) == 0) send_calm = !send_calm;
         if (!paused && sent_count >= SCRIPT_LEN + ITEMS / 2) begin
            // hold off until every reply has come back
            req_if.valid <= 1'b0;
            do @(posedge clock); while (reply_q.size() != 0);
            paused = 1'b1;
         end
         roll = $urandom_range(0, 99);
         if (roll < 3) begin
            // newline burst to push the row past the screen, then scroll
            run = $urandom_range(20, 60);
            repeat (run) send_req('{FUNC_PUT, CHAR_NEWLINE, {$urandom, $urandom},
                                    READ_ROW_W'($urandom), READ_COL_W'($urandom)},
                                  1'b0, '0);
            send_req(glyph_req(), 1'b0, '0);
         end else if (roll < 8) begin
            // long line running into the right edge
            run = $urandom_range(60, 100);
            repeat (run) send_req(glyph_req(), 1'b0, '0);
         end else begin
            send_req(random_req(), 1'b0, '0);
         end
      end
      req_if.valid <= 1'b0;

      // drain
      while (reply_q.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (fail_count == 0 && reply_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
